@@ hw/rtl/htfd_pkg.sv @@
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// 45 * 65535, the offset of the temperature transfer function.
	localparam logic [23:0] TEMP_OFFSET = 24'd2949075;
	localparam logic [23:0] TEMP_SCALE = 24'd175;
	localparam logic [23:0] HUM_SCALE = 24'd100;
	localparam logic [23:0] HALF_FULL_SCALE = 24'd32767;
	localparam logic [16:0] FULL_SCALE = 17'd65535;

	typedef enum logic [2:0] {
		POS_T_HI,
		POS_T_LO,
		POS_T_CRC,
		POS_H_HI,
		POS_H_LO,
		POS_H_CRC
	} byte_pos_t;

	typedef struct packed {
		logic status;
		logic [15:0] raw_t;
		logic [15:0] raw_h;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/htfd_frame.sv @@
module htfd_frame import htfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tuser,
	output logic       frame_valid,
	input  logic       frame_ready,
	output frame_t     frame
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	byte_pos_t  pos_q;
	logic [7:0] crc_q;
	logic [15:0] tword_q;
	logic [15:0] hword_q;
	logic       tok_q;

	logic       valid_s2;
	frame_t     frame_s2;

	byte_pos_t  pos;
	byte_pos_t  pos_d;
	logic [7:0] crc_d;
	logic [15:0] tword_d;
	logic [15:0] hword_d;
	logic       tok_d;
	logic       last_byte;
	logic       frame_ok;
	logic       s2_free;
	logic       consume;

	assign pos = start_s1 ? POS_T_HI : pos_q;

	always_comb begin
		pos_d = pos_q;
		crc_d = crc_q;
		tword_d = tword_q;
		hword_d = hword_q;
		tok_d = tok_q;
		unique case (pos)
			POS_T_LO: begin
				crc_d = crc8_byte(crc_q, byte_s1);
				tword_d = {tword_q[15:8], byte_s1};
				pos_d = POS_T_CRC;
			end
			POS_T_CRC: begin
				tok_d = (crc_q == byte_s1);
				crc_d = CRC_INIT;
				pos_d = POS_H_HI;
			end
			POS_H_HI: begin
				crc_d = crc8_byte(CRC_INIT, byte_s1);
				hword_d = {byte_s1, 8'h00};
				pos_d = POS_H_LO;
			end
			POS_H_LO: begin
				crc_d = crc8_byte(crc_q, byte_s1);
				hword_d = {hword_q[15:8], byte_s1};
				pos_d = POS_H_CRC;
			end
			POS_H_CRC: begin
				crc_d = CRC_INIT;
				pos_d = POS_T_HI;
			end
			default: begin
				crc_d = crc8_byte(CRC_INIT, byte_s1);
				tword_d = {byte_s1, 8'h00};
				pos_d = POS_T_LO;
			end
		endcase
	end

	always_comb begin
		last_byte = (pos == POS_H_CRC);
		frame_ok = tok_q && (crc_q == byte_s1);
	end

	assign s2_free = !valid_s2 || frame_ready;
	assign consume = valid_s1 && (!last_byte || s2_free);
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q <= POS_T_HI;
			crc_q <= CRC_INIT;
			tword_q <= '0;
			hword_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (consume) begin
				pos_q <= pos_d;
				crc_q <= crc_d;
				tword_q <= tword_d;
				hword_q <= hword_d;
				tok_q <= tok_d;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1 && last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
		if (valid_s1 && last_byte && s2_free) begin
			frame_s2.status <= !frame_ok;
			frame_s2.raw_t <= frame_ok ? tword_q : 16'h0000;
			frame_s2.raw_h <= frame_ok ? hword_q : 16'h0000;
		end
	end

	assign frame_valid = valid_s2;
	assign frame = frame_s2;

endmodule

@@ hw/rtl/htfd_convert.sv @@
module htfd_convert import htfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_ready,
	input  frame_t      frame,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tuser
);

	// Rounded quotient by 65535 for values well below 2^24: split by 65536, fold
	// the high part back in, then one compare and subtract.
	function automatic logic [7:0] div_round(input logic [23:0] mag);
		logic [23:0] x;
		logic [16:0] r;
		x = mag + HALF_FULL_SCALE;
		r = {1'b0, x[15:0]} + {9'd0, x[23:16]};
		return x[23:16] + {7'd0, (r >= FULL_SCALE)};
	endfunction

	logic        valid_s3;
	frame_t      frame_s3;
	logic        neg_s3;
	logic [23:0] tmag_s3;
	logic [23:0] hmag_s3;

	logic        valid_s4;
	frame_t      frame_s4;
	logic [8:0]  temp_s4;
	logic [6:0]  hum_s4;

	logic [23:0] tprod;
	logic        tneg;
	logic [23:0] tdiff;
	logic [7:0]  tq;
	logic [7:0]  hq;
	logic        ready4;

	always_comb begin
		tprod = {8'd0, frame.raw_t} * TEMP_SCALE;
		tneg = (tprod < TEMP_OFFSET);
		tdiff = tneg ? (TEMP_OFFSET - tprod) : (tprod - TEMP_OFFSET);
		tq = div_round(tmag_s3);
		hq = div_round(hmag_s3);
	end

	assign ready4 = !valid_s4 || m_axis_tready;
	assign frame_ready = !valid_s3 || ready4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (frame_ready) begin
				valid_s3 <= frame_valid;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			frame_s3 <= frame;
			neg_s3 <= tneg;
			tmag_s3 <= tdiff;
			hmag_s3 <= {8'd0, frame.raw_h} * HUM_SCALE;
		end
		if (valid_s3 && ready4) begin
			frame_s4 <= frame_s3;
			if (frame_s3.status) begin
				temp_s4 <= '0;
				hum_s4 <= '0;
			end else begin
				temp_s4 <= neg_s3 ? (9'd0 - {1'b0, tq}) : {1'b0, tq};
				hum_s4 <= hq[6:0];
			end
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tuser = frame_s4.status;
	assign m_axis_tdata = {hum_s4, temp_s4, frame_s4.raw_h, frame_s4.raw_t};

endmodule

@@ hw/rtl/humidity_temp_frame_decoder.sv @@
// Decoder for the six-byte measurement frame of a temperature/humidity sensor.
// The slave stream carries one frame byte per item: temperature word (high byte
// first), its CRC-8, humidity word (high byte first), its CRC-8. A set tuser bit
// restarts the frame at the byte it comes with. The CRC-8 uses polynomial 0x31,
// initial value 0xFF, and is checked over each word on its own.
// After the sixth byte the master stream carries one item: tuser is set on a
// CRC mismatch, and then all of tdata is zero. Otherwise tdata holds the raw
// words, the rounded temperature in degrees Celsius and the rounded humidity.
// A byte is accepted in every cycle unless a stalled receiver has filled the
// stages. The last byte of a frame passes the input register, the frame check,
// the product register and the scaling stage, which is the output register.
// Reset clears all valid flags and the frame position, so the next byte is
// taken as the first byte of a frame. When the receiver stalls, the result waits
// in the output register while bytes keep flowing until a second and third
// finished result fill the stages behind it; tready falls at the next last byte.
module humidity_temp_frame_decoder import htfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [15:0] raw_temperature, [31:16] raw_humidity,
	                                   // [40:32] temperature_c, [47:41] humidity_pct
	output logic        m_axis_tuser   // [0] status
);

	logic   frame_valid;
	logic   frame_ready;
	frame_t frame;

	htfd_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame)
	);

	htfd_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("failed frame carries nonzero data");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[47:41] <= 7'd100 &&
			$signed(m_axis_tdata[40:32]) >= -9'sd45 &&
			$signed(m_axis_tdata[40:32]) <= 9'sd130)
		else $error("converted value out of range");

	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(frame))
		else $error("frame result lost between stages");

endmodule
